// File: design/lrmp_pkg.sv
// package with the modulus, register codes and modular helpers for the recurrence block
`default_nettype none
package lrmp_pkg;

  localparam int unsigned VAL_BITS = 30;
  localparam logic [VAL_BITS-1:0] PRIME = 30'd1000000007;
  localparam int unsigned REG_IDX_BITS = 3;

  typedef logic [VAL_BITS-1:0] val_t;

  // configuration register codes
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_COEF_ONE    = 3'd0,
    REG_COEF_TWO    = 3'd1,
    REG_COEF_THREE  = 3'd2,
    REG_FIRST_TERM  = 3'd3,
    REG_SECOND_TERM = 3'd4,
    REG_THIRD_TERM  = 3'd5
  } reg_code_t;

  // status from the serial multiplier to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

  // reduce a 30-bit value, which is always below twice the modulus
  function automatic val_t mod_reduce(input val_t v);
    val_t r;
    r = (v >= PRIME) ? v - PRIME : v;
    return r;
  endfunction

  // sum of two residues, reduced
  function automatic val_t mod_add(input val_t a, input val_t b);
    logic [VAL_BITS:0] s;
    logic [VAL_BITS:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, PRIME};
    return (s >= {1'b0, PRIME}) ? d[VAL_BITS-1:0] : s[VAL_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/lrmp_mulmod.sv
// bit-serial modular multiplier, one bit of the second operand per cycle, msb first
`default_nettype none
module lrmp_mulmod (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire lrmp_pkg::val_t   op_a,
  input  wire lrmp_pkg::val_t   op_b,
  output lrmp_pkg::val_t        prod,
  output lrmp_pkg::mm_status_t  status
);
  import lrmp_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(VAL_BITS);
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(VAL_BITS - 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  val_t                acc_r;
  val_t                a_r;
  val_t                b_r;
  val_t                dbl;
  val_t                acc_nxt;

  // double the partial product, then add the multiplicand when the bit is set
  always_comb begin
    dbl     = mod_add(acc_r, acc_r);
    acc_nxt = mod_add(dbl, b_r[VAL_BITS-1] ? a_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= op_a;
        b_r    <= op_b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[VAL_BITS-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod        = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule
`default_nettype wire

// File: design/linear_recurrence_matrix_power_mod.sv
// top level: term n of a third-order linear recurrence modulo 1000000007
`default_nettype none
// Returns f(n) for f(n) = c1*f(n-1) + c2*f(n-2) + c3*f(n-3) mod 1000000007, with the
// coefficients and f(1..3) held in configuration registers. Indexes of zero to three
// present their result through the done state and the output register. Larger indexes
// raise the 3x3 companion matrix to the power n-3 by square and multiply, one exponent
// bit per round, every matrix entry built from three products on a single bit-serial
// modular multiplier. A 3x3 product is 27 of these followed by a commit in the copy
// state; a round costs one 3x3 product for a zero bit and two for a one bit. One item
// is in flight at a time; the result sits in an output register.
module linear_recurrence_matrix_power_mod #(
  parameter int unsigned INDEX_BITS = 62
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [INDEX_BITS-1:0] in_term_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lrmp_pkg::val_t             out_term_value,
  input  wire logic                  cfg_wr_en,
  input  wire logic [lrmp_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  wire lrmp_pkg::val_t        cfg_data
);
  import lrmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD_ISSUE,
    S_PROD_WAIT,
    S_COPY,
    S_DOT_ISSUE,
    S_DOT_WAIT,
    S_DONE
  } state_t;

  state_t              state_r;
  val_t                coef1_r, coef2_r, coef3_r, term1_r, term2_r, term3_r;
  val_t                f1_r, f2_r, f3_r;
  val_t                acc_r  [9];
  val_t                base_r [9];
  val_t                ycp_r  [9];
  val_t                res_r  [9];
  val_t                sum_r;
  val_t                final_r;
  logic [INDEX_BITS-1:0] e_r;
  logic                sq_r;
  logic [1:0]          i_r, j_r, k_r;
  logic                out_valid_r;
  val_t                out_value_r;

  logic [3:0]          idx_ik, idx_kj, idx_ij;
  val_t                op_a, op_b;
  logic                mm_start;
  val_t                mm_prod;
  mm_status_t          mm_stat;
  val_t                sum_new;
  logic [INDEX_BITS-1:0] e_start;
  logic [INDEX_BITS-1:0] e_shift;

  // matrix entry addressing
  always_comb begin
    idx_ik = 4'({i_r, 1'b0}) + 4'(i_r) + 4'(k_r);
    idx_kj = 4'({k_r, 1'b0}) + 4'(k_r) + 4'(j_r);
    idx_ij = 4'({i_r, 1'b0}) + 4'(i_r) + 4'(j_r);
  end

  // multiplier operand selection
  always_comb begin
    if (state_r == S_DOT_ISSUE) begin
      op_a = acc_r[4'(k_r)];
      case (k_r)
        2'd0:    op_b = f3_r;
        2'd1:    op_b = f2_r;
        default: op_b = f1_r;
      endcase
    end else begin
      op_a = sq_r ? base_r[idx_ik] : acc_r[idx_ik];
      op_b = ycp_r[idx_kj];
    end
  end

  assign mm_start = (state_r == S_PROD_ISSUE) || (state_r == S_DOT_ISSUE);
  assign sum_new  = mod_add(sum_r, mm_prod);
  assign e_start  = in_term_index - INDEX_BITS'(3);
  assign e_shift  = e_r >> 1;

  lrmp_mulmod u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod   (mm_prod),
    .status (mm_stat)
  );

  // sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      coef1_r     <= 30'd1;
      coef2_r     <= 30'd2;
      coef3_r     <= 30'd1;
      term1_r     <= 30'd1;
      term2_r     <= 30'd12;
      term3_r     <= 30'd13;
      sq_r        <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      e_r         <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      // register writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_COEF_ONE:    coef1_r <= cfg_data;
          REG_COEF_TWO:    coef2_r <= cfg_data;
          REG_COEF_THREE:  coef3_r <= cfg_data;
          REG_FIRST_TERM:  term1_r <= cfg_data;
          REG_SECOND_TERM: term2_r <= cfg_data;
          REG_THIRD_TERM:  term3_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            f1_r <= mod_reduce(term1_r);
            f2_r <= mod_reduce(term2_r);
            f3_r <= mod_reduce(term3_r);
            i_r  <= '0;
            j_r  <= '0;
            k_r  <= '0;
            sum_r <= '0;
            if (in_term_index <= INDEX_BITS'(1)) begin
              final_r <= mod_reduce(term1_r);
              state_r <= S_DONE;
            end else if (in_term_index == INDEX_BITS'(2)) begin
              final_r <= mod_reduce(term2_r);
              state_r <= S_DONE;
            end else if (in_term_index == INDEX_BITS'(3)) begin
              final_r <= mod_reduce(term3_r);
              state_r <= S_DONE;
            end else begin
              // companion matrix and identity
              base_r[0] <= mod_reduce(coef1_r);
              base_r[1] <= mod_reduce(coef2_r);
              base_r[2] <= mod_reduce(coef3_r);
              base_r[3] <= 30'd1;
              base_r[4] <= '0;
              base_r[5] <= '0;
              base_r[6] <= '0;
              base_r[7] <= 30'd1;
              base_r[8] <= '0;
              ycp_r[0]  <= mod_reduce(coef1_r);
              ycp_r[1]  <= mod_reduce(coef2_r);
              ycp_r[2]  <= mod_reduce(coef3_r);
              ycp_r[3]  <= 30'd1;
              ycp_r[4]  <= '0;
              ycp_r[5]  <= '0;
              ycp_r[6]  <= '0;
              ycp_r[7]  <= 30'd1;
              ycp_r[8]  <= '0;
              for (int m = 0; m < 9; m++) begin
                acc_r[m] <= (m == 0 || m == 4 || m == 8) ? 30'd1 : 30'd0;
              end
              e_r     <= e_start;
              sq_r    <= !e_start[0];
              state_r <= S_PROD_ISSUE;
            end
          end
        end
        S_PROD_ISSUE: begin
          state_r <= S_PROD_WAIT;
        end
        S_PROD_WAIT: begin
          if (mm_stat.done) begin
            if (k_r == 2'd2) begin
              res_r[idx_ij] <= sum_new;
              sum_r <= '0;
              k_r   <= '0;
              if (j_r == 2'd2) begin
                j_r <= '0;
                if (i_r == 2'd2) begin
                  i_r     <= '0;
                  state_r <= S_COPY;
                end else begin
                  i_r     <= i_r + 1'b1;
                  state_r <= S_PROD_ISSUE;
                end
              end else begin
                j_r     <= j_r + 1'b1;
                state_r <= S_PROD_ISSUE;
              end
            end else begin
              sum_r   <= sum_new;
              k_r     <= k_r + 1'b1;
              state_r <= S_PROD_ISSUE;
            end
          end
        end
        S_COPY: begin
          // commit the product, then step to the next multiply, the next exponent bit or the dot product
          if (!sq_r) begin
            acc_r   <= res_r;
            sq_r    <= 1'b1;
            state_r <= S_PROD_ISSUE;
          end else begin
            base_r <= res_r;
            ycp_r  <= res_r;
            e_r    <= e_shift;
            if (e_shift == '0) begin
              state_r <= S_DOT_ISSUE;
            end else begin
              sq_r    <= !e_shift[0];
              state_r <= S_PROD_ISSUE;
            end
          end
        end
        S_DOT_ISSUE: begin
          state_r <= S_DOT_WAIT;
        end
        S_DOT_WAIT: begin
          if (mm_stat.done) begin
            if (k_r == 2'd2) begin
              k_r     <= '0;
              final_r <= sum_new;
              state_r <= S_DONE;
            end else begin
              sum_r   <= sum_new;
              k_r     <= k_r + 1'b1;
              state_r <= S_DOT_ISSUE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_value_r <= final_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_term_value = out_value_r;

  // the multiplier is never restarted while it is still working
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  // every delivered value is a residue
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r < PRIME))
    else $error("result not reduced");

  // matrix products run only with exponent bits left
  a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROD_ISSUE) |-> (e_r != '0))
    else $error("product issued with exhausted exponent");

  // a new item enters only after the multiplier went quiet
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !mm_stat.busy)
    else $error("item accepted while multiplier busy");

endmodule
`default_nettype wire
